[rtl/upc_pkg.sv]
// ----------------------------------------------------------------------------
// upc_pkg
// Types, widths, register map and reset values for the ultrasonic presence
// counter.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int TICK_W   = 20;
  localparam int SPEED_W  = 10;
  localparam int THR_W    = 28;
  localparam int TRIG_W   = 8;
  localparam int DIST_W   = 29;
  localparam int VISIT_W  = 16;
  localparam int CONF_W   = 2;
  localparam int PROD_W   = TICK_W + SPEED_W;
  localparam int REGIDX_W = 3;

  localparam logic [REGIDX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_SOUND_SPEED    = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_ECHO_TIMEOUT   = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_TRIG_LOW       = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_TRIG_HIGH      = 3'd4;

  localparam logic [THR_W-1:0]   RST_NEAR_THRESHOLD = 28'd300000;
  localparam logic [SPEED_W-1:0] RST_SOUND_SPEED    = 10'd343;
  localparam logic [TICK_W-1:0]  RST_ECHO_TIMEOUT   = 20'd1000000;
  localparam logic [TRIG_W-1:0]  RST_TRIG_LOW       = 8'd2;
  localparam logic [TRIG_W-1:0]  RST_TRIG_HIGH      = 8'd10;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_TLOW  = 5'b00010,
    PH_THIGH = 5'b00100,
    PH_WAIT  = 5'b01000,
    PH_MEAS  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              run;
    logic              valid;
    logic              trig;
    logic              stuck_lo;
    logic              stuck_hi;
    logic [TICK_W-1:0] width;
  } meas_t;

endpackage

[rtl/upc_intf.sv]
// ----------------------------------------------------------------------------
// upc_intf
// Valid/ready channels for echo samples and per-tick results.
// ----------------------------------------------------------------------------
interface upc_sample_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic run_enable;

  modport source(output valid, echo_level, run_enable, input ready);
  modport sink(input valid, echo_level, run_enable, output ready);
endinterface

interface upc_result_if;
  logic                         valid;
  logic                         ready;
  logic                         trig_level;
  logic                         dist_valid;
  logic [upc_pkg::DIST_W-1:0]   distance_um;
  logic                         visit_event;
  logic [upc_pkg::VISIT_W-1:0]  visit_count;
  logic                         armed;
  logic                         echo_stuck_low;
  logic                         echo_stuck_high;

  modport source(output valid, trig_level, dist_valid, distance_um, visit_event,
                 visit_count, armed, echo_stuck_low, echo_stuck_high,
                 input ready);
  modport sink(input valid, trig_level, dist_valid, distance_um, visit_event,
               visit_count, armed, echo_stuck_low, echo_stuck_high,
               output ready);
endinterface

[rtl/ultrasonic_presence_counter_core.sv]
// ----------------------------------------------------------------------------
// ultrasonic_presence_counter_core
// Ultrasonic ranging sequencer with echo timing, distance scaling and visit
// counting. One sample transaction per microsecond tick, one result each.
// Path: a sample transaction is taken into the sequencer register; distance
//   multiply and visit logic then load the result register, which drives valid.
// Throughput: one transaction per cycle unless result back-pressure stalls it.
// Reset: synchronous, active high; phase idle, counters and visits clear,
//   armed set, configuration registers at their defaults.
// ----------------------------------------------------------------------------
module ultrasonic_presence_counter_core #(
  parameter int CONFIRM_SAMPLES = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  upc_sample_if.sink                   sample,
  upc_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [upc_pkg::ADDR_W-1:0]   paddr,
  input  logic [upc_pkg::DATA_W-1:0]   pwdata,
  output logic [upc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [upc_pkg::THR_W-1:0]    near_threshold;
  logic [upc_pkg::SPEED_W-1:0]  sound_speed;
  logic [upc_pkg::TICK_W-1:0]   echo_timeout;
  logic [upc_pkg::TRIG_W-1:0]   trig_low;
  logic [upc_pkg::TRIG_W-1:0]   trig_high;
  logic [upc_pkg::REGIDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  upc_pkg::phase_t              phase, phase_next, ph_cur;
  logic [upc_pkg::TICK_W-1:0]   tick, tick_next, tc_cur, tc_inc;
  logic [upc_pkg::TICK_W-1:0]   timeout1;
  logic [upc_pkg::TRIG_W-1:0]   tlow1, thigh1;
  upc_pkg::meas_t               meas, s1;
  logic                         s1_valid;
  logic                         accept, load_out;

  logic [upc_pkg::PROD_W-1:0]   prod;
  logic [upc_pkg::DIST_W-1:0]   dist_um;
  logic                         near, hit, event_next;
  logic [upc_pkg::CONF_W-1:0]   confirm, confirm_next, conf_inc;
  logic                         armed_q, armed_next;
  logic [upc_pkg::VISIT_W-1:0]  visits, visits_next;
  logic [upc_pkg::DIST_W-1:0]   last_distance, last_next;

  logic                         o_valid;
  logic                         o_trig, o_dist_valid, o_event, o_armed;
  logic                         o_stuck_lo, o_stuck_hi;
  logic [upc_pkg::DIST_W-1:0]   o_distance;
  logic [upc_pkg::VISIT_W-1:0]  o_visits;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[upc_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= upc_pkg::RST_NEAR_THRESHOLD;
      sound_speed    <= upc_pkg::RST_SOUND_SPEED;
      echo_timeout   <= upc_pkg::RST_ECHO_TIMEOUT;
      trig_low       <= upc_pkg::RST_TRIG_LOW;
      trig_high      <= upc_pkg::RST_TRIG_HIGH;
    end else if (cfg_wr) begin
      case (reg_idx)
        upc_pkg::REG_NEAR_THRESHOLD: near_threshold <= pwdata[upc_pkg::THR_W-1:0];
        upc_pkg::REG_SOUND_SPEED:    sound_speed    <= pwdata[upc_pkg::SPEED_W-1:0];
        upc_pkg::REG_ECHO_TIMEOUT:   echo_timeout   <= pwdata[upc_pkg::TICK_W-1:0];
        upc_pkg::REG_TRIG_LOW:       trig_low       <= pwdata[upc_pkg::TRIG_W-1:0];
        upc_pkg::REG_TRIG_HIGH:      trig_high      <= pwdata[upc_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      upc_pkg::REG_NEAR_THRESHOLD: prdata = upc_pkg::DATA_W'(near_threshold);
      upc_pkg::REG_SOUND_SPEED:    prdata = upc_pkg::DATA_W'(sound_speed);
      upc_pkg::REG_ECHO_TIMEOUT:   prdata = upc_pkg::DATA_W'(echo_timeout);
      upc_pkg::REG_TRIG_LOW:       prdata = upc_pkg::DATA_W'(trig_low);
      upc_pkg::REG_TRIG_HIGH:      prdata = upc_pkg::DATA_W'(trig_high);
      default:                     prdata = '0;
    endcase
  end

  // handshake
  assign load_out     = !o_valid || result.ready;
  assign sample.ready = !s1_valid || load_out;
  assign accept       = sample.valid && sample.ready;

  // ranging sequencer
  assign timeout1 = (echo_timeout == '0) ? upc_pkg::TICK_W'(1) : echo_timeout;
  assign tlow1    = (trig_low == '0) ? upc_pkg::TRIG_W'(1) : trig_low;
  assign thigh1   = (trig_high == '0) ? upc_pkg::TRIG_W'(1) : trig_high;

  always_comb begin
    ph_cur     = (phase == upc_pkg::PH_IDLE) ? upc_pkg::PH_TLOW : phase;
    tc_cur     = (phase == upc_pkg::PH_IDLE) ? '0 : tick;
    tc_inc     = tc_cur + upc_pkg::TICK_W'(1);
    phase_next = ph_cur;
    tick_next  = tc_cur;
    meas       = '0;
    meas.run   = sample.run_enable;
    if (!sample.run_enable) begin
      phase_next = upc_pkg::PH_IDLE;
      tick_next  = '0;
    end else begin
      case (ph_cur)
        upc_pkg::PH_TLOW: begin
          tick_next = tc_inc;
          if (tc_inc >= upc_pkg::TICK_W'(tlow1)) begin
            phase_next = upc_pkg::PH_THIGH;
            tick_next  = '0;
          end
        end
        upc_pkg::PH_THIGH: begin
          meas.trig = 1'b1;
          tick_next = tc_inc;
          if (tc_inc >= upc_pkg::TICK_W'(thigh1)) begin
            phase_next = upc_pkg::PH_WAIT;
            tick_next  = '0;
          end
        end
        upc_pkg::PH_WAIT: begin
          if (sample.echo_level) begin
            phase_next = upc_pkg::PH_MEAS;
            tick_next  = upc_pkg::TICK_W'(1);
            if (timeout1 == upc_pkg::TICK_W'(1)) begin
              meas.valid    = 1'b1;
              meas.stuck_hi = 1'b1;
              meas.width    = upc_pkg::TICK_W'(1);
            end
          end else begin
            tick_next = tc_inc;
            if (tc_inc >= timeout1) begin
              meas.valid    = 1'b1;
              meas.stuck_lo = 1'b1;
            end
          end
        end
        upc_pkg::PH_MEAS: begin
          if (sample.echo_level) begin
            tick_next = tc_inc;
            if (tc_inc >= timeout1) begin
              meas.valid    = 1'b1;
              meas.stuck_hi = 1'b1;
              meas.width    = tc_inc;
            end
          end else begin
            meas.valid = 1'b1;
            meas.width = tc_cur;
          end
        end
        default: begin
          phase_next = upc_pkg::PH_TLOW;
          tick_next  = '0;
        end
      endcase
      if (meas.valid) begin
        phase_next = upc_pkg::PH_TLOW;
        tick_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= upc_pkg::PH_IDLE;
      tick     <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase    <= phase_next;
        tick     <= tick_next;
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= meas;
    end
  end

  // distance and visit tracking
  assign prod     = upc_pkg::PROD_W'(s1.width) * upc_pkg::PROD_W'(sound_speed);
  assign dist_um  = prod[upc_pkg::PROD_W-1 -: upc_pkg::DIST_W];
  assign near     = dist_um <= upc_pkg::DIST_W'(near_threshold);
  assign hit      = armed_q ? near : !near;
  assign conf_inc = confirm + upc_pkg::CONF_W'(1);

  always_comb begin
    confirm_next = confirm;
    armed_next   = armed_q;
    visits_next  = visits;
    last_next    = last_distance;
    event_next   = 1'b0;
    if (!s1.run) begin
      confirm_next = '0;
      visits_next  = '0;
    end else if (s1.valid) begin
      last_next = dist_um;
      if (!hit) begin
        confirm_next = '0;
      end else if (conf_inc >= upc_pkg::CONF_W'(CONFIRM_SAMPLES)) begin
        confirm_next = '0;
        armed_next   = !armed_q;
        if (armed_q) begin
          visits_next = visits + upc_pkg::VISIT_W'(1);
          event_next  = 1'b1;
        end
      end else begin
        confirm_next = conf_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm       <= '0;
      armed_q       <= 1'b1;
      visits        <= '0;
      last_distance <= '0;
      o_valid       <= 1'b0;
    end else if (load_out) begin
      o_valid <= s1_valid;
      if (s1_valid) begin
        confirm       <= confirm_next;
        armed_q       <= armed_next;
        visits        <= visits_next;
        last_distance <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && s1_valid) begin
      o_trig       <= s1.trig;
      o_dist_valid <= s1.valid;
      o_distance   <= last_next;
      o_event      <= event_next;
      o_visits     <= visits_next;
      o_armed      <= armed_next;
      o_stuck_lo   <= s1.stuck_lo;
      o_stuck_hi   <= s1.stuck_hi;
    end
  end

  assign result.valid           = o_valid;
  assign result.trig_level      = o_trig;
  assign result.dist_valid      = o_dist_valid;
  assign result.distance_um     = o_distance;
  assign result.visit_event     = o_event;
  assign result.visit_count     = o_visits;
  assign result.armed           = o_armed;
  assign result.echo_stuck_low  = o_stuck_lo;
  assign result.echo_stuck_high = o_stuck_hi;

  a_stuck_needs_valid: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_stuck_lo || o_stuck_hi) |-> o_dist_valid && !(o_stuck_lo && o_stuck_hi))
    else $error("stuck flag without finished measurement");

  a_event_disarms: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_event |-> o_dist_valid && !o_armed && !o_trig)
    else $error("visit event without measurement or disarm");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> s1_valid && o_valid && !result.ready)
    else $error("sample stalled with free pipeline");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    phase == upc_pkg::PH_IDLE |-> tick == '0)
    else $error("tick count not clear in idle");

endmodule

[sim/ultrasonic_presence_counter_core_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_presence_counter_core_tb
// Self-checking bench for the ultrasonic presence counter. Drives one echo
// sample transaction per tick and predicts each result in step: trigger
// sequencing, echo timing with both timeouts, distance scaling and visit
// arming. It also checks register access over APB. Both channels stall at
// random; one phase holds the result side off long enough to back up the
// sample side.
// ----------------------------------------------------------------------------
module ultrasonic_presence_counter_core_tb;

  localparam int VISIT_CONFIRM = 3;
  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  // longest quiet stretch: a config phase of APB transfers or one hold
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic                        trig;
    logic                        dist_valid;
    logic [upc_pkg::DIST_W-1:0]  distance;
    logic                        visit_event;
    logic [upc_pkg::VISIT_W-1:0] visit_count;
    logic                        armed;
    logic                        stuck_low;
    logic                        stuck_high;
  } tick_result_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [upc_pkg::ADDR_W-1:0] paddr;
  logic [upc_pkg::DATA_W-1:0] pwdata;
  logic [upc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  upc_sample_if sample_ch();
  upc_result_if result_ch();

  ultrasonic_presence_counter_core u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register shadow
  logic [upc_pkg::THR_W-1:0]   cfg_thr;
  logic [upc_pkg::SPEED_W-1:0] cfg_speed;
  logic [upc_pkg::TICK_W-1:0]  cfg_timeout;
  logic [upc_pkg::TRIG_W-1:0]  cfg_tlow;
  logic [upc_pkg::TRIG_W-1:0]  cfg_thigh;

  // ranger and visit state
  upc_pkg::phase_t             ranger_phase;
  logic [upc_pkg::TICK_W-1:0]  ranger_ticks;
  logic [upc_pkg::CONF_W-1:0]  confirm_run;
  logic                        armed_state;
  logic [upc_pkg::VISIT_W-1:0] visit_total;
  logic [upc_pkg::DIST_W-1:0]  last_distance;

  tick_result_t expected_ticks[$];
  int unsigned  error_count;
  bit           idle_on;
  int unsigned  holds_asked;
  int unsigned  holds_served;
  int unsigned  hold_left;
  int unsigned  quiet_cycles;

  // pulse shaping for well-formed ranging
  bit          near_mode;
  bit          plan_fresh;
  int unsigned width_goal;
  int unsigned wait_goal;
  int unsigned wait_cnt;
  int unsigned off_left;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic string fmt_result(tick_result_t r);
    return $sformatf("trig=%0b dv=%0b dist=%0d ev=%0b cnt=%0d armed=%0b lo=%0b hi=%0b",
                     r.trig, r.dist_valid, r.distance, r.visit_event, r.visit_count,
                     r.armed, r.stuck_low, r.stuck_high);
  endfunction

  function automatic logic [upc_pkg::TICK_W-1:0] nonzero(logic [upc_pkg::TICK_W-1:0] v);
    return (v == '0) ? upc_pkg::TICK_W'(1) : v;
  endfunction

  function automatic tick_result_t predict_tick(logic echo, logic run);
    tick_result_t               r;
    logic [upc_pkg::TICK_W-1:0] limit;
    logic [upc_pkg::TICK_W-1:0] width;
    logic [upc_pkg::PROD_W-1:0] prod;
    logic                       done;
    logic                       lo;
    logic                       hi;
    logic                       trig;
    logic                       ev;
    logic                       near;
    logic                       hit;
    limit = nonzero(cfg_timeout);
    width = '0;
    done  = 1'b0;
    lo    = 1'b0;
    hi    = 1'b0;
    trig  = 1'b0;
    ev    = 1'b0;
    if (!run) begin
      ranger_phase = upc_pkg::PH_IDLE;
      ranger_ticks = '0;
      confirm_run  = '0;
      visit_total  = '0;
    end else begin
      if (ranger_phase == upc_pkg::PH_IDLE) begin
        ranger_phase = upc_pkg::PH_TLOW;
        ranger_ticks = '0;
      end
      case (ranger_phase)
        upc_pkg::PH_TLOW: begin
          ranger_ticks++;
          if (ranger_ticks >= nonzero(upc_pkg::TICK_W'(cfg_tlow))) begin
            ranger_phase = upc_pkg::PH_THIGH;
            ranger_ticks = '0;
          end
        end
        upc_pkg::PH_THIGH: begin
          trig = 1'b1;
          ranger_ticks++;
          if (ranger_ticks >= nonzero(upc_pkg::TICK_W'(cfg_thigh))) begin
            ranger_phase = upc_pkg::PH_WAIT;
            ranger_ticks = '0;
          end
        end
        upc_pkg::PH_WAIT: begin
          if (echo) begin
            ranger_ticks = upc_pkg::TICK_W'(1);
            ranger_phase = upc_pkg::PH_MEAS;
            if (ranger_ticks >= limit) begin
              done  = 1'b1;
              hi    = 1'b1;
              width = ranger_ticks;
            end
          end else begin
            ranger_ticks++;
            if (ranger_ticks >= limit) begin
              done = 1'b1;
              lo   = 1'b1;
            end
          end
        end
        default: begin
          if (echo) begin
            ranger_ticks++;
            if (ranger_ticks >= limit) begin
              done  = 1'b1;
              hi    = 1'b1;
              width = ranger_ticks;
            end
          end else begin
            done  = 1'b1;
            width = ranger_ticks;
          end
        end
      endcase
      if (done) begin
        prod          = upc_pkg::PROD_W'(width) * upc_pkg::PROD_W'(cfg_speed);
        last_distance = prod[upc_pkg::PROD_W-1:1];
        ranger_phase  = upc_pkg::PH_TLOW;
        ranger_ticks  = '0;
        near = (last_distance <= upc_pkg::DIST_W'(cfg_thr));
        hit  = armed_state ? near : !near;
        if (!hit) begin
          confirm_run = '0;
        end else begin
          confirm_run++;
          if (confirm_run >= VISIT_CONFIRM) begin
            confirm_run = '0;
            if (armed_state) begin
              visit_total++;
              ev = 1'b1;
            end
            armed_state = !armed_state;
          end
        end
      end
    end
    r = '{trig, done, last_distance, ev, visit_total, armed_state, lo, hi};
    return r;
  endfunction

  function automatic logic [upc_pkg::ADDR_W-1:0] reg_addr(logic [upc_pkg::REGIDX_W-1:0] idx);
    return upc_pkg::ADDR_W'(idx) << 2;
  endfunction

  function automatic logic [upc_pkg::DATA_W-1:0] cfg_value(logic [upc_pkg::REGIDX_W-1:0] idx);
    case (idx)
      upc_pkg::REG_NEAR_THRESHOLD: return upc_pkg::DATA_W'(cfg_thr);
      upc_pkg::REG_SOUND_SPEED:    return upc_pkg::DATA_W'(cfg_speed);
      upc_pkg::REG_ECHO_TIMEOUT:   return upc_pkg::DATA_W'(cfg_timeout);
      upc_pkg::REG_TRIG_LOW:       return upc_pkg::DATA_W'(cfg_tlow);
      upc_pkg::REG_TRIG_HIGH:      return upc_pkg::DATA_W'(cfg_thigh);
      default:                     return '0;
    endcase
  endfunction

  task automatic apb_xfer(input logic write, input logic [upc_pkg::ADDR_W-1:0] addr,
                          input logic [upc_pkg::DATA_W-1:0] wdata,
                          output logic [upc_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(logic [upc_pkg::REGIDX_W-1:0] idx);
    logic [upc_pkg::DATA_W-1:0] rd;
    apb_xfer(1'b0, reg_addr(idx), '0, rd);
    if (rd !== cfg_value(idx))
      flag_error($sformatf("register %0d readback: want %0h got %0h", idx, cfg_value(idx), rd));
  endtask

  task automatic check_registers();
    for (int i = 0; i <= upc_pkg::REG_TRIG_HIGH; i++) check_register(upc_pkg::REGIDX_W'(i));
  endtask

  task automatic cfg_write(logic [upc_pkg::REGIDX_W-1:0] idx,
                           logic [upc_pkg::DATA_W-1:0] value);
    logic [upc_pkg::DATA_W-1:0] unused_rd;
    apb_xfer(1'b1, reg_addr(idx), value, unused_rd);
    case (idx)
      upc_pkg::REG_NEAR_THRESHOLD: cfg_thr     = value[upc_pkg::THR_W-1:0];
      upc_pkg::REG_SOUND_SPEED:    cfg_speed   = value[upc_pkg::SPEED_W-1:0];
      upc_pkg::REG_ECHO_TIMEOUT:   cfg_timeout = value[upc_pkg::TICK_W-1:0];
      upc_pkg::REG_TRIG_LOW:       cfg_tlow    = value[upc_pkg::TRIG_W-1:0];
      upc_pkg::REG_TRIG_HIGH:      cfg_thigh   = value[upc_pkg::TRIG_W-1:0];
      default: ;
    endcase
    if (idx <= upc_pkg::REG_TRIG_HIGH) check_register(idx);
  endtask

  task automatic set_ranging(logic [upc_pkg::DATA_W-1:0] thr,
                             logic [upc_pkg::DATA_W-1:0] speed,
                             logic [upc_pkg::DATA_W-1:0] timeout,
                             logic [upc_pkg::DATA_W-1:0] tlow,
                             logic [upc_pkg::DATA_W-1:0] thigh);
    cfg_write(upc_pkg::REG_NEAR_THRESHOLD, thr);
    cfg_write(upc_pkg::REG_SOUND_SPEED, speed);
    cfg_write(upc_pkg::REG_ECHO_TIMEOUT, timeout);
    cfg_write(upc_pkg::REG_TRIG_LOW, tlow);
    cfg_write(upc_pkg::REG_TRIG_HIGH, thigh);
  endtask

  task automatic send_tick(logic echo, logic run);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.echo_level <= echo;
    sample_ch.run_enable <= run;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    expected_ticks.insert(expected_ticks.size(), predict_tick(echo, run));
  endtask

  // bit n-1 goes first
  task automatic send_bits(int n, logic [31:0] echoes, logic [31:0] runs);
    for (int i = n - 1; i >= 0; i--) send_tick(echoes[i], runs[i]);
  endtask

  task automatic wait_results_done();
    sample_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic run_ranging(int unsigned count);
    int unsigned split;
    logic        echo;
    logic        run;
    split = (cfg_speed == '0) ? 4 : (2 * int'(cfg_thr)) / int'(cfg_speed);
    if (split < 1) split = 1;
    if (split > 6) split = 6;
    repeat (count) begin
      run = 1'b1;
      if (off_left > 0) begin
        run = 1'b0;
        off_left--;
      end else if ($urandom_range(0, 199) == 0) begin
        run      = 1'b0;
        off_left = $urandom_range(0, 2);
      end
      case (ranger_phase)
        upc_pkg::PH_WAIT: begin
          plan_fresh = 1'b0;
          echo = (wait_cnt >= wait_goal);
          wait_cnt++;
        end
        upc_pkg::PH_MEAS: begin
          plan_fresh = 1'b0;
          echo = (ranger_ticks < width_goal);
        end
        default: begin
          if (!plan_fresh) begin
            if ($urandom_range(0, 99) < 20) near_mode = !near_mode;
            width_goal = near_mode ? $urandom_range(1, split)
                                   : $urandom_range(split + 1, 2 * split);
            wait_goal  = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 12)
                                                      : $urandom_range(0, 2);
            wait_cnt   = 0;
            plan_fresh = 1'b1;
          end
          echo = 1'($urandom_range(0, 1));
        end
      endcase
      if ($urandom_range(0, 99) < 8) echo = !echo;
      send_tick(echo, run);
    end
  endtask

  task automatic test_register_reset();
    check_registers();
  endtask

  task automatic test_register_access();
    set_ranging('1, '1, '1, '1, '1);
    for (int i = upc_pkg::REG_TRIG_HIGH + 1; i < 2 ** upc_pkg::REGIDX_W; i++)
      cfg_write(upc_pkg::REGIDX_W'(i), '0);
    check_registers();
    set_ranging('0, '0, '0, '0, '0);
  endtask

  task automatic test_measurement_cases();
    set_ranging(1000, 1023, 3, 1, 2);
    send_bits(7, 32'b1111110, 32'b0111111);  // disabled tick, then a two-tick echo
    send_bits(6, 32'b000000, 32'b111111);    // echo never rises
    send_bits(7, 32'b1111111, 32'b1111111);  // echo stays high past the timeout
    send_bits(2, 32'b00, 32'b10);            // drop run in the trigger pulse
    wait_results_done();
  endtask

  task automatic test_zero_registers();
    set_ranging(1000, 0, 0, 0, 0);
    send_bits(6, 32'b000001, 32'b111111);
    wait_results_done();
  endtask

  task automatic test_default_ranging();
    set_ranging(upc_pkg::DATA_W'(upc_pkg::RST_NEAR_THRESHOLD),
                upc_pkg::DATA_W'(upc_pkg::RST_SOUND_SPEED),
                upc_pkg::DATA_W'(upc_pkg::RST_ECHO_TIMEOUT),
                upc_pkg::DATA_W'(upc_pkg::RST_TRIG_LOW),
                upc_pkg::DATA_W'(upc_pkg::RST_TRIG_HIGH));
    run_ranging(80);
    wait_results_done();
  endtask

  task automatic test_trigger_extremes();
    set_ranging(32'hFFFF_FFFF, 1023, 32'hFFFFF, 255, 255);
    idle_on = 1'b0;
    run_ranging(530);
    wait_results_done();
    idle_on = 1'b1;
  endtask

  task automatic test_visit_counting();
    set_ranging(1000, 500, 6, 1, 1);
    run_ranging(250);
    wait_results_done();
  endtask

  task automatic test_backpressure();
    set_ranging(0, 1, 10, 2, 3);
    idle_on = 1'b0;
    holds_asked++;
    run_ranging(70);
    wait_results_done();
    idle_on = 1'b1;
    run_ranging(60);
    wait_results_done();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        tick_result_t got;
        tick_result_t want;
        got = {result_ch.trig_level, result_ch.dist_valid, result_ch.distance_um,
               result_ch.visit_event, result_ch.visit_count, result_ch.armed,
               result_ch.echo_stuck_low, result_ch.echo_stuck_high};
        if (expected_ticks.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %s", fmt_result(got)));
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want)
            flag_error($sformatf("result mismatch: want %s / got %s",
                                 fmt_result(want), fmt_result(got)));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    sample_ch.valid      <= 1'b0;
    sample_ch.echo_level <= 1'b0;
    sample_ch.run_enable <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    cfg_thr      = upc_pkg::RST_NEAR_THRESHOLD;
    cfg_speed    = upc_pkg::RST_SOUND_SPEED;
    cfg_timeout  = upc_pkg::RST_ECHO_TIMEOUT;
    cfg_tlow     = upc_pkg::RST_TRIG_LOW;
    cfg_thigh    = upc_pkg::RST_TRIG_HIGH;
    ranger_phase  = upc_pkg::PH_IDLE;
    ranger_ticks  = '0;
    confirm_run   = '0;
    armed_state   = 1'b1;
    visit_total   = '0;
    last_distance = '0;
    error_count  = 0;
    idle_on      = 1'b1;
    holds_asked  = 0;
    holds_served = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    near_mode    = 1'b1;
    plan_fresh   = 1'b0;
    width_goal   = 1;
    wait_goal    = 0;
    wait_cnt     = 0;
    off_left     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_register_access();
    test_measurement_cases();
    test_zero_registers();
    test_default_ranging();
    test_trigger_extremes();
    test_visit_counting();
    test_backpressure();

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_ticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
